[rtl/core/ppfm_pkg.sv]
package ppfm_pkg;

    // Timer setup: one overflow spans (256 - reload) fine ticks
    localparam int unsigned TIMER_RELOAD = 0;
    localparam int unsigned SPAN_BASE    = 256;
    localparam logic [8:0]  TICK_SPAN    = 9'((SPAN_BASE - (TIMER_RELOAD % 256)) % 512);

    // Speed scale applied to ratio * (pulses - 1)
    localparam logic [12:0] SPEED_SCALE = 13'd7800;

    // Field widths
    localparam int unsigned RATIO_W  = 24;
    localparam int unsigned OFFSET_W = 32;
    localparam int unsigned SPEED_W  = 32;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned SPAN_W   = 16;
    localparam int unsigned PROD_W   = RATIO_W + COUNT_W;
    localparam int unsigned DIV_W    = PROD_W + 13;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
    localparam int unsigned SUM_W    = DIV_W + 1;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 24'h010000;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

    // Command codes
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_PULSE = 2'd1,
        CMD_READ  = 2'd2
    } ppfm_cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_VALID      = 2'd0,
        ST_FEW_PULSES = 2'd1,
        ST_ZERO_SPAN  = 2'd2
    } ppfm_status_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_FLOW_RATIO  = 1'b0,
        REG_FLOW_OFFSET = 1'b1
    } ppfm_reg_t;

    // What the pulse store tells the sequencer about the current window
    typedef struct packed {
        logic              few_pulses;
        logic              zero_span;
        logic [COUNT_W-1:0] pulses_less_one;
        logic [SPAN_W-1:0]  span;
    } ppfm_view_t;

endpackage

[rtl/core/ppfm_cmd_if.sv]
interface ppfm_cmd_if;
    import ppfm_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] timer_count;
    logic [7:0] overflow_count;

    modport source (output valid, output cmd, output timer_count, output overflow_count,
                    input ready);
    modport sink   (input valid, input cmd, input timer_count, input overflow_count,
                    output ready);
endinterface

[rtl/core/ppfm_res_if.sv]
interface ppfm_res_if;
    import ppfm_pkg::*;

    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] flow_speed;
    logic [1:0]         status;

    modport source (output valid, output flow_speed, output status, input ready);
    modport sink   (input valid, input flow_speed, input status, output ready);
endinterface

[rtl/core/ppfm_cfg_if.sv]
interface ppfm_cfg_if;
    import ppfm_pkg::*;

    logic                valid;
    logic                ready;
    logic [0:0]          index;
    logic [OFFSET_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/pulse_period_frequency_meter_top.sv]
// Flow-sensor frequency meter. Clear and pulse words give no result. A read
// word gives one result: ratio * (pulses - 1) is formed as the word is taken,
// the product is scaled by 7800 as it loads the divider, a bit-serial
// restoring divide of the 53-bit scaled product by the 16-bit mark span
// follows, and the finish state adds the offset and saturates to signed
// Q16.16. The block takes no word while a read is in progress; a read that
// fails (fewer than two pulses or zero span) skips the divide and gives its
// result from the finish state, with zero speed and its status.
// Results sit in an output register, so a new word can be taken while the
// previous result waits; a finished read holds until that register is free.
// Configuration writes are always taken.
module pulse_period_frequency_meter_top
    import ppfm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ppfm_cmd_if.sink    command,
    ppfm_res_if.source  result,
    ppfm_cfg_if.sink    setup
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MUL    = 4'b0010,
        S_DIV    = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [RATIO_W-1:0]  flow_ratio_reg, flow_ratio_next;
    logic [OFFSET_W-1:0] flow_offset_reg, flow_offset_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [1:0]          code_reg, code_next;
    logic                out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0]  speed_reg, speed_next;
    logic [1:0]          status_reg, status_next;

    logic               take;
    logic               cfg_take;
    logic               out_free;
    logic               div_start;
    logic               div_done;
    logic [DIV_W-1:0]   scaled;
    logic [DIV_W-1:0]   quotient;
    logic signed [SUM_W-1:0] sum;
    logic [SPEED_W-1:0] saturated;
    ppfm_view_t         view;

    assign take     = command.valid && command.ready;
    assign cfg_take = setup.valid && setup.ready;
    assign out_free = !out_valid_reg || result.ready;

    ppfm_store u_store (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .cmd            (command.cmd),
        .timer_count    (command.timer_count),
        .overflow_count (command.overflow_count),
        .view           (view)
    );

    // Scale the first product by the speed constant straight into the divider
    assign scaled    = DIV_W'(prod_reg) * DIV_W'(SPEED_SCALE);
    assign div_start = (state_reg == S_MUL);

    ppfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scaled),
        .divisor  (view.span),
        .done     (div_done),
        .quotient (quotient)
    );

    // Add offset and clamp to the signed 32-bit range
    assign sum = $signed({1'b0, quotient})
               + $signed({{(SUM_W - OFFSET_W){flow_offset_reg[OFFSET_W-1]}}, flow_offset_reg});

    always_comb
    begin
        if (!sum[SUM_W-1] && (|sum[SUM_W-2:SPEED_W-1]))
            saturated = {1'b0, {(SPEED_W - 1){1'b1}}};
        else if (sum[SUM_W-1] && !(&sum[SUM_W-2:SPEED_W-1]))
            saturated = {1'b1, {(SPEED_W - 1){1'b0}}};
        else
            saturated = sum[SPEED_W-1:0];
    end

    // Capture configuration words
    always_comb
    begin
        flow_ratio_next  = flow_ratio_reg;
        flow_offset_next = flow_offset_reg;
        if (cfg_take)
        begin
            unique case (setup.index)
                REG_FLOW_RATIO:  flow_ratio_next  = setup.data[RATIO_W-1:0];
                REG_FLOW_OFFSET: flow_offset_next = setup.data;
                default:         flow_ratio_next  = flow_ratio_reg;
            endcase
        end
    end

    // Sequence a read through multiply, divide and finish
    always_comb
    begin
        state_next     = state_reg;
        prod_next      = prod_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg;
        speed_next     = speed_reg;
        status_next    = status_reg;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take && command.cmd == CMD_READ)
                begin
                    if (view.few_pulses)
                    begin
                        code_next  = ST_FEW_PULSES;
                        state_next = S_FINISH;
                    end
                    else if (view.zero_span)
                    begin
                        code_next  = ST_ZERO_SPAN;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        code_next  = ST_VALID;
                        prod_next  = PROD_W'(flow_ratio_reg) * PROD_W'(view.pulses_less_one);
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = code_reg;
                    speed_next     = (code_reg == ST_VALID) ? saturated : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            flow_ratio_reg  <= RATIO_RESET;
            flow_offset_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            flow_ratio_reg  <= flow_ratio_next;
            flow_offset_reg <= flow_offset_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Hold datapath, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        code_reg   <= code_next;
        speed_reg  <= speed_next;
        status_reg <= status_next;
    end

    assign command.ready     = (state_reg == S_IDLE);
    assign setup.ready       = 1'b1;
    assign result.valid      = out_valid_reg;
    assign result.flow_speed = speed_reg;
    assign result.status     = status_reg;

    // The divider only finishes while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    // A taken read always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && command.cmd == CMD_READ) |=> state_reg != S_IDLE)
        else $error("read word taken without starting a read");

    // An error result carries zero speed
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != ST_VALID) |-> result.flow_speed == '0)
        else $error("error result with nonzero speed");

    // A new result is only loaded when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> result.valid && $stable(result.flow_speed))
        else $error("pending result overwritten");

endmodule

[rtl/core/ppfm_store.sv]
module ppfm_store
    import ppfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [1:0] cmd,
    input  logic [7:0] timer_count,
    input  logic [7:0] overflow_count,
    output ppfm_view_t view
);

    logic [COUNT_W-1:0] pulse_total_reg, pulse_total_next;
    logic [7:0] first_stamp_reg, first_stamp_next;
    logic [7:0] first_wraps_reg, first_wraps_next;
    logic [7:0] last_stamp_reg, last_stamp_next;
    logic [7:0] last_wraps_reg, last_wraps_next;
    logic [COUNT_W-1:0] bumped;
    logic [16:0] first_wide;
    logic [16:0] last_wide;
    logic [SPAN_W-1:0] span;

    // Update the window on clear and pulse words
    always_comb
    begin
        pulse_total_next = pulse_total_reg;
        first_stamp_next = first_stamp_reg;
        first_wraps_next = first_wraps_reg;
        last_stamp_next  = last_stamp_reg;
        last_wraps_next  = last_wraps_reg;
        bumped = (pulse_total_reg == COUNT_MAX) ? pulse_total_reg : pulse_total_reg + 16'd1;
        if (take)
        begin
            unique case (cmd)
                CMD_CLEAR:
                begin
                    pulse_total_next = '0;
                    first_stamp_next = '0;
                    first_wraps_next = '0;
                    last_stamp_next  = '0;
                    last_wraps_next  = '0;
                end
                CMD_PULSE:
                begin
                    pulse_total_next = bumped;
                    if (bumped == 16'd1)
                    begin
                        first_stamp_next = timer_count;
                        first_wraps_next = overflow_count;
                    end
                    else
                    begin
                        last_stamp_next = timer_count;
                        last_wraps_next = overflow_count;
                    end
                end
                default:
                begin
                    pulse_total_next = pulse_total_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_total_reg <= '0;
            first_stamp_reg <= '0;
            first_wraps_reg <= '0;
            last_stamp_reg  <= '0;
            last_wraps_reg  <= '0;
        end
        else
        begin
            pulse_total_reg <= pulse_total_next;
            first_stamp_reg <= first_stamp_next;
            first_wraps_reg <= first_wraps_next;
            last_stamp_reg  <= last_stamp_next;
            last_wraps_reg  <= last_wraps_next;
        end
    end

    // Form both marks and the wrapping span between them
    assign first_wide = 17'(first_wraps_reg) * 17'(TICK_SPAN) + 17'(first_stamp_reg);
    assign last_wide  = 17'(last_wraps_reg) * 17'(TICK_SPAN) + 17'(last_stamp_reg);
    assign span       = last_wide[15:0] - first_wide[15:0];

    assign view.few_pulses      = (pulse_total_reg <= 16'd1);
    assign view.zero_span       = (span == '0);
    assign view.pulses_less_one = pulse_total_reg - 16'd1;
    assign view.span            = span;

endmodule

[rtl/core/ppfm_div.sv]
module ppfm_div
    import ppfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [SPAN_W-1:0] divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    logic [SPAN_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [SPAN_W:0]      shifted;
    logic [SPAN_W:0]      diff;
    logic                 fits;
    logic                 last_step;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign shifted   = {rem_reg, quo_reg[DIV_W-1]};
    assign diff      = shifted - {1'b0, divisor};
    assign fits      = (shifted >= {1'b0, divisor});
    assign last_step = (cnt_reg == DIV_CNT_W'(DIV_W - 1));

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[SPAN_W-1:0] : shifted[SPAN_W-1:0];
            quo_next  = {quo_reg[DIV_W-2:0], fits};
            cnt_next  = cnt_reg + DIV_CNT_W'(1);
            busy_next = !last_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // Hold datapath, no reset needed
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = busy_reg && last_step;
    assign quotient = quo_reg;

endmodule

[sim/ppfm_flow_checker.sv]
module ppfm_flow_checker
    import ppfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ppfm_cmd_if        command,
    ppfm_res_if        result,
    ppfm_cfg_if        setup,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SPEED_HI = 64'sd2147483647;
    localparam longint SPEED_LO = -64'sd2147483648;

    typedef struct {
        logic [SPEED_W-1:0] flow_speed;
        ppfm_status_t       status;
    } flow_reading_t;

    // Shadow of the calibration registers and the pulse store
    logic [RATIO_W-1:0]         ratio_q;
    logic signed [OFFSET_W-1:0] offset_q;
    logic [COUNT_W-1:0]         pulse_total;
    logic [7:0]                 start_stamp;
    logic [7:0]                 start_wraps;
    logic [7:0]                 end_stamp;
    logic [7:0]                 end_wraps;

    flow_reading_t expected_readings[$];

    function automatic logic [SPAN_W-1:0] mark_ticks(logic [7:0] stamp, logic [7:0] wraps);
        logic [SPAN_W-1:0] ticks;
        ticks = SPAN_W'(stamp) + SPAN_W'(wraps) * SPAN_W'(TICK_SPAN);
        return ticks;
    endfunction

    // Apply one command word to the shadow store; queue a reading on a read
    function automatic void track_command(logic [1:0] code, logic [7:0] stamp,
                                          logic [7:0] wraps);
        flow_reading_t      reading;
        logic [SPAN_W-1:0]  span;
        longint unsigned    quotient;
        longint             speed;
        longint             offset_ext;

        case (code)
            CMD_CLEAR:
            begin
                pulse_total = '0;
                start_stamp = '0;
                start_wraps = '0;
                end_stamp   = '0;
                end_wraps   = '0;
            end
            CMD_PULSE:
            begin
                if (pulse_total != COUNT_MAX)
                    pulse_total = pulse_total + COUNT_W'(1);
                if (pulse_total == COUNT_W'(1))
                begin
                    start_stamp = stamp;
                    start_wraps = wraps;
                end
                else
                begin
                    end_stamp = stamp;
                    end_wraps = wraps;
                end
            end
            CMD_READ:
            begin
                span = mark_ticks(end_stamp, end_wraps) - mark_ticks(start_stamp, start_wraps);
                reading.flow_speed = '0;
                if (pulse_total <= COUNT_W'(1))
                    reading.status = ST_FEW_PULSES;
                else if (span == '0)
                    reading.status = ST_ZERO_SPAN;
                else
                begin
                    quotient = 64'(SPEED_SCALE) * 64'(ratio_q)
                             * 64'(pulse_total - COUNT_W'(1));
                    quotient = quotient / 64'(span);
                    offset_ext = offset_q;
                    speed = longint'(quotient) + offset_ext;
                    if (speed > SPEED_HI)
                        speed = SPEED_HI;
                    else if (speed < SPEED_LO)
                        speed = SPEED_LO;
                    reading.flow_speed = speed[SPEED_W-1:0];
                    reading.status = ST_VALID;
                end
                expected_readings.push_back(reading);
            end
            default: ;
        endcase
    endfunction

    // Watch all three channels and compare each result word
    always @(posedge clk or negedge rst_n)
    begin
        flow_reading_t want;
        if (!rst_n)
        begin
            ratio_q     = RATIO_RESET;
            offset_q    = '0;
            pulse_total = '0;
            start_stamp = '0;
            start_wraps = '0;
            end_stamp   = '0;
            end_wraps   = '0;
            expected_readings.delete();
            fail_count  = 0;
        end
        else
        begin
            if (setup.valid && setup.ready)
            begin
                if (setup.index == REG_FLOW_RATIO)
                    ratio_q = setup.data[RATIO_W-1:0];
                else
                    offset_q = setup.data;
            end
            if (command.valid && command.ready)
                track_command(command.cmd, command.timer_count, command.overflow_count);
            if (result.valid && result.ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $error("result word with no reading expected: flow_speed %0d status %0d",
                           $signed(result.flow_speed), result.status);
                    fail_count++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (result.flow_speed !== want.flow_speed)
                    begin
                        $error("flow_speed mismatch: expected %0d, actual %0d",
                               $signed(want.flow_speed), $signed(result.flow_speed));
                        fail_count++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, result.status);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_readings.size();
    end

endmodule

[sim/tb_pulse_period_frequency_meter_top.sv]
module tb_pulse_period_frequency_meter_top;
    import ppfm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         SETTLE_CYC  = 70;
    localparam int         HOLD_CYC    = 800;
    localparam int         PHASE_WORDS = 300;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_token;
    int   words_sent;

    ppfm_cmd_if command_bus();
    ppfm_res_if result_bus();
    ppfm_cfg_if setup_bus();

    pulse_period_frequency_meter_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .command (command_bus),
        .result  (result_bus),
        .setup   (setup_bus)
    );

    ppfm_flow_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .command    (command_bus),
        .result     (result_bus),
        .setup      (setup_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Give up on a hung run
    initial
    begin
        #24_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_seen;
        hold_seen = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                repeat (HOLD_CYC)
                begin
                    result_bus.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one command word and hold it until taken
    task automatic send_word(input logic [1:0] code, input logic [7:0] stamp,
                             input logic [7:0] wraps);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            command_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        command_bus.valid          <= 1'b1;
        command_bus.cmd            <= code;
        command_bus.timer_count    <= stamp;
        command_bus.overflow_count <= wraps;
        do @(posedge clk); while (!command_bus.ready);
        if (code != CMD_UNUSED)
            words_sent++;
    endtask

    // Drop valid and wait until every reading is back and the block is quiet
    task automatic settle();
        command_bus.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Write both calibration registers back to back
    task automatic write_calibration(input logic [RATIO_W-1:0] ratio,
                                     input logic [OFFSET_W-1:0] offset);
        setup_bus.valid <= 1'b1;
        setup_bus.index <= REG_FLOW_RATIO;
        setup_bus.data  <= OFFSET_W'(ratio);
        do @(posedge clk); while (!setup_bus.ready);
        setup_bus.index <= REG_FLOW_OFFSET;
        setup_bus.data  <= offset;
        do @(posedge clk); while (!setup_bus.ready);
        setup_bus.valid <= 1'b0;
    endtask

    // One measurement window: clear, a run of pulses with occasional reads among them, then one or two reads
    task automatic send_window();
        int         n_pulses;
        logic [7:0] wraps;
        send_word(CMD_CLEAR, 8'($urandom), 8'($urandom));
        n_pulses = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
        wraps = 8'($urandom);
        repeat (n_pulses)
        begin
            if ($urandom_range(3) == 0)
                wraps = wraps + 8'($urandom_range(80));
            else
                wraps = wraps + 8'($urandom_range(3));
            if ($urandom_range(19) == 0)
                wraps = 8'($urandom);
            send_word(CMD_PULSE, 8'($urandom), wraps);
            if ($urandom_range(99) < 15)
                send_word(CMD_READ, 8'($urandom), 8'($urandom));
        end
        send_word(CMD_READ, 8'($urandom), 8'($urandom));
        if ($urandom_range(3) == 0)
            send_word(CMD_READ, 8'($urandom), 8'($urandom));
    endtask

    // Mostly whole windows, the rest stray words of any code
    task automatic run_random(input int n_words);
        int start;
        start = words_sent;
        while (words_sent - start < n_words)
        begin
            if ($urandom_range(99) < 80)
                send_window();
            else
                send_word(2'($urandom_range(3)), 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_token     = 0;
        words_sent     = 0;
        rst_n          = 1'b0;
        command_bus.valid          <= 1'b0;
        command_bus.cmd            <= CMD_CLEAR;
        command_bus.timer_count    <= '0;
        command_bus.overflow_count <= '0;
        setup_bus.valid <= 1'b0;
        setup_bus.index <= REG_FLOW_RATIO;
        setup_bus.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset calibration, status codes, field extremes
        send_word(CMD_READ, 8'd0, 8'd0);
        send_word(CMD_PULSE, 8'd0, 8'd0);
        send_word(CMD_READ, 8'd255, 8'd255);
        send_word(CMD_PULSE, 8'd0, 8'd0);
        send_word(CMD_READ, 8'd0, 8'd0);
        send_word(CMD_PULSE, 8'd255, 8'd255);
        send_word(CMD_READ, 8'd0, 8'd0);
        send_word(CMD_UNUSED, 8'd255, 8'd255);
        send_word(CMD_READ, 8'd0, 8'd0);
        send_word(CMD_CLEAR, 8'd255, 8'd255);
        send_word(CMD_READ, 8'd0, 8'd0);
        // end mark before start mark: span wraps
        send_word(CMD_PULSE, 8'd200, 8'd10);
        send_word(CMD_PULSE, 8'd5, 8'd3);
        send_word(CMD_READ, 8'd0, 8'd0);
        // one-tick span with six pulses: saturate high
        send_word(CMD_CLEAR, 8'd0, 8'd0);
        send_word(CMD_PULSE, 8'd200, 8'd10);
        repeat (4) send_word(CMD_PULSE, 8'd100, 8'd10);
        send_word(CMD_PULSE, 8'd201, 8'd10);
        send_word(CMD_READ, 8'd0, 8'd0);
        settle();

        // Largest gain and offset; fill the block behind a long result hold-off
        write_calibration('1, 32'h7FFF_FFFF);
        hold_token++;
        send_word(CMD_CLEAR, 8'd0, 8'd0);
        repeat (10)
        begin
            send_word(CMD_PULSE, 8'($urandom), 8'($urandom));
            send_word(CMD_READ, 8'd0, 8'd0);
        end
        run_random(PHASE_WORDS);
        settle();

        // Zero gain, most negative offset; sender idles
        write_calibration('0, 32'h8000_0000);
        send_idle_pct = 58;
        run_random(PHASE_WORDS / 2);
        settle();
        write_calibration(RATIO_W'($urandom), 32'($urandom));
        run_random(PHASE_WORDS / 2);
        settle();

        // Random calibration; receiver stalls
        send_idle_pct  = 0;
        recv_stall_pct = 58;
        write_calibration(RATIO_W'($urandom), 32'($urandom));
        run_random(PHASE_WORDS);
        settle();

        // Unity gain, small offset; both sides idle now and then
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        write_calibration(RATIO_RESET, 32'($signed($urandom_range(131072)) - 65536));
        run_random(PHASE_WORDS);
        settle();

        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
